[hw/rtl/position_broadcast_frame_parser_core_defines.svh]
// Assertion macros shared by the parser RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef POSITION_BROADCAST_FRAME_PARSER_CORE_DEFINES_SVH
`define POSITION_BROADCAST_FRAME_PARSER_CORE_DEFINES_SVH

// Implication checked every cycle outside reset.
`define PBFP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PBFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pbfp_pkg.sv]
// Package for the position broadcast frame parser: types and constants.
// No dependencies.
package pbfp_pkg;

  localparam int unsigned FrameCapacityDef = 128;
  localparam logic [7:0] StartMark = 8'h3E;
  localparam logic [7:0] EndMark   = 8'h3B;
  localparam logic [7:0] LetterRst  = 8'd68;
  localparam logic [7:0] TimeoutRst = 8'd5;

  typedef enum logic {
    CfgRobotLetter = 1'b0,
    CfgIdleTimeout = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       frame_ok;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic       has_position;
    logic       in_start_zone;
    logic       in_end_zone;
  } out_item_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

[hw/rtl/pbfp_stream_if.sv]
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given as a type parameter.
interface pbfp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/pbfp_fifo.sv]
// Two-entry queue between the front and the back of the parser.
// Depends on pbfp_stream_if.
module pbfp_fifo #(
  parameter type payload_t = logic
) (
  input logic clk_i,
  input logic rst_ni,
  pbfp_stream_if.sink   in_s,
  pbfp_stream_if.source out_s
);
  payload_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_s.ready  = (cnt_q != 2'd2);
  assign out_s.valid = (cnt_q != 2'd0);
  assign out_s.data  = mem_q[rptr_q];
  assign push = in_s.valid && in_s.ready;
  assign pop  = out_s.valid && out_s.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_s.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[hw/rtl/pbfp_front.sv]
// Front end: byte framing, delay line, checksum and entry decoding.
// Depends on pbfp_pkg and pbfp_stream_if; emits a verdict at each ';'.
module pbfp_front #(
  parameter int unsigned FrameCapacity = pbfp_pkg::FrameCapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] robot_letter_i,
  input  logic [7:0] idle_timeout_i,
  pbfp_stream_if.sink   in_s,
  pbfp_stream_if.source out_s
);
  import pbfp_pkg::*;
  `include "position_broadcast_frame_parser_core_defines.svh"

  localparam int unsigned LenW = $clog2(FrameCapacity);

  logic [LenW-1:0] len_q, len_d;
  logic broken_q, broken_d;
  logic [5:0] sum_q, sum_d;
  logic [7:0] dly0_q, dly0_d, dly1_q, dly1_d;
  logic [2:0] phase_q, phase_d;
  logic [9:0] acc_q, acc_d;
  logic match_q, match_d, bad_q, bad_d;
  logic [9:0] ex_q, ex_d, fx_q, fx_d, fy_q, fy_d;
  logic found_q, found_d;
  logic [7:0] idle_q, idle_d;

  // Verdict record: valid-with-self, found x, found y.
  typedef struct packed {
    logic       ok;
    logic [9:0] x;
    logic [9:0] y;
  } verdict_t;

  in_item_t it;
  logic     take, emit;
  verdict_t verd;

  assign it   = in_s.data;
  assign take = in_s.valid && in_s.ready;

  // Stall only when a verdict is due and the queue is full.
  assign in_s.ready = out_s.ready || it.func || (it.rx_byte != EndMark);
  assign out_s.valid = in_s.valid && !it.func && (it.rx_byte == EndMark);
  assign out_s.data = verd;

  always_comb begin
    logic [7:0] b, d;
    logic [LenW-1:0] idx;
    logic [9:0] acc_n;
    logic valid;
    logic [6:0] tx;
    logic [5:0] calc;
    b = it.rx_byte;
    d = dly0_q;
    idx = len_q - LenW'(2);
    acc_n = '0;
    valid = 1'b0;
    tx = '0;
    calc = '0;
    len_d = len_q; broken_d = broken_q; sum_d = sum_q;
    dly0_d = dly0_q; dly1_d = dly1_q; phase_d = phase_q;
    acc_d = acc_q; match_d = match_q; bad_d = bad_q; ex_d = ex_q;
    found_d = found_q; fx_d = fx_q; fy_d = fy_q; idle_d = idle_q;
    emit = 1'b0;

    tx = 7'((dly0_q - 8'h30) * 4'd10) + 7'(dly1_q - 8'h30);
    calc = sum_q + EndMark[5:0];
    valid = (len_q < LenW'(FrameCapacity - 1)) && (len_q >= LenW'(12)) &&
            !broken_q && is_digit(dly0_q) && is_digit(dly1_q) &&
            ({1'b0, calc} == tx);
    verd.ok = valid && found_q;
    verd.x  = fx_q;
    verd.y  = fy_q;

    if (take) begin
      if (it.func) begin
        if (idle_q != 8'hFF) idle_d = idle_q + 8'd1;
        if ((len_q != '0) && (idle_d >= idle_timeout_i)) begin
          len_d = '0;
        end
      end else begin
        idle_d = '0;
        if (b == EndMark) begin
          emit = 1'b1;
          len_d = '0;
        end else if ((b != StartMark) && (len_q >= LenW'(FrameCapacity - 1))) begin
          len_d = '0;
        end else begin
          if (b == StartMark) begin
            len_d = '0;
          end else begin
            // Append: body byte from the delay line when two are held.
            if (b == 8'h00) broken_d = 1'b1;
            if (len_q >= LenW'(2)) begin
              sum_d = sum_q + d[5:0];
              if (idx == '0) begin
                if (d != StartMark) broken_d = 1'b1;
              end else if (idx < LenW'(6)) begin
                if (!is_digit(d)) broken_d = 1'b1;
              end else if (phase_q == 3'd0) begin
                match_d = (d == robot_letter_i);
                bad_d = 1'b0;
                acc_d = '0;
                phase_d = 3'd1;
              end else begin
                acc_n = acc_q;
                if (is_digit(d)) acc_n = 10'(acc_q * 4'd10) + 10'(d - 8'h30);
                else bad_d = 1'b1;
                acc_d = acc_n;
                if (phase_q == 3'd3) begin
                  ex_d = acc_n;
                  acc_d = '0;
                end
                if (phase_q == 3'd6) begin
                  if (bad_d) broken_d = 1'b1;
                  else if (match_q) begin
                    found_d = 1'b1;
                    fx_d = ex_q;
                    fy_d = acc_n;
                  end
                  acc_d = '0;
                  phase_d = 3'd0;
                end else begin
                  phase_d = phase_q + 3'd1;
                end
              end
            end
            dly0_d = dly1_q;
            dly1_d = b;
            len_d = len_q + LenW'(1);
          end
        end
        // Start mark: fresh frame holding only '>'.
        if (b == StartMark) begin
          len_d = LenW'(1);
        end
      end
      // Any clearing of the frame resets the per-frame state.
      if ((len_d == '0) || (!it.func && b == StartMark)) begin
        broken_d = 1'b0; sum_d = '0; phase_d = '0; acc_d = '0;
        match_d = 1'b0; bad_d = 1'b0; ex_d = '0; found_d = 1'b0;
        fx_d = '0; fy_d = '0; dly0_d = '0;
        dly1_d = (!it.func && b == StartMark) ? StartMark : 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; broken_q <= 1'b0; sum_q <= '0; dly0_q <= '0; dly1_q <= '0;
      phase_q <= '0; acc_q <= '0; match_q <= 1'b0; bad_q <= 1'b0; ex_q <= '0;
      found_q <= 1'b0; fx_q <= '0; fy_q <= '0; idle_q <= '0;
    end else begin
      len_q <= len_d; broken_q <= broken_d; sum_q <= sum_d; dly0_q <= dly0_d;
      dly1_q <= dly1_d; phase_q <= phase_d; acc_q <= acc_d; match_q <= match_d;
      bad_q <= bad_d; ex_q <= ex_d; found_q <= found_d; fx_q <= fx_d;
      fy_q <= fy_d; idle_q <= idle_d;
    end
  end

  `PBFP_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, take && emit, len_q == '0, "frame not cleared")
  `PBFP_ASSERT_IMP(a_phase_rng, clk_i, rst_ni, 1'b1, phase_q <= 3'd6, "phase out of range")
  `PBFP_ASSERT_NEXT(a_tick_idle, clk_i, rst_ni, take && it.func, idle_q != '0, "idle not counting")
endmodule

[hw/rtl/pbfp_back.sv]
// Back end: commits positions and builds result transactions.
// Depends on pbfp_pkg and pbfp_stream_if.
module pbfp_back #(
  parameter type verdict_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  pbfp_stream_if.sink   in_s,
  pbfp_stream_if.source out_s
);
  import pbfp_pkg::*;
  `include "position_broadcast_frame_parser_core_defines.svh"

  logic [9:0] cx_q, cy_q, nx, ny;
  logic       pv_q, npv;
  logic       ovalid_q;
  out_item_t  odata_q, nres;
  verdict_t   v;
  logic       take;

  assign v = in_s.data;
  assign in_s.ready = !ovalid_q || out_s.ready;
  assign take = in_s.valid && in_s.ready;
  assign out_s.valid = ovalid_q;
  assign out_s.data  = odata_q;

  always_comb begin
    nx  = v.ok ? v.x : cx_q;
    ny  = v.ok ? v.y : cy_q;
    npv = v.ok || pv_q;
    nres.frame_ok = v.ok;
    nres.pos_x = nx;
    nres.pos_y = ny;
    nres.has_position = npv;
    nres.in_start_zone = npv && nx >= 10'd45 && nx <= 10'd53 && ny >= 10'd2 && ny <= 10'd15;
    nres.in_end_zone = npv && nx >= 10'd86 && nx <= 10'd100 && ny >= 10'd18 && ny <= 10'd33;
  end

  always_ff @(posedge clk_i) begin
    if (take) odata_q <= nres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; pv_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        cx_q <= nx; cy_q <= ny; pv_q <= npv;
        ovalid_q <= 1'b1;
      end else if (out_s.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  `PBFP_ASSERT_NEXT(a_has_sticky, clk_i, rst_ni, pv_q, pv_q, "position lost")
  `PBFP_ASSERT_IMP(a_zone_excl, clk_i, rst_ni, ovalid_q, !(odata_q.in_start_zone && odata_q.in_end_zone), "both zones")
  `PBFP_ASSERT_NEXT(a_commit, clk_i, rst_ni, take && v.ok, pv_q && cx_q == $past(v.x), "commit missed")
endmodule

[hw/rtl/position_broadcast_frame_parser_core.sv]
// Top level of the position broadcast frame parser.
// Depends on pbfp_pkg, pbfp_stream_if, pbfp_front, pbfp_fifo and pbfp_back.

// The parser takes one transaction per clock: received bytes and millisecond
// ticks enter the front end, which keeps the frame state, a two-byte delay
// line that holds back the checksum digits, the running sum mod 64 and the
// entry decoder. At each ';' the front end hands a verdict (frame good and
// held our letter, plus the found position) into a two-entry queue; the back
// end commits the position and presents the result in an output register.
// The verdict for a ';' is registered in the queue and then in the output
// register; the parser takes one transaction per cycle, stalling only a ';' that arrives while the queue is full.
// Configuration: index 0 is the robot letter (reset 'D'), index 1 the idle
// timeout in ticks (reset 5). Write only while the parser is idle.
module position_broadcast_frame_parser_core #(
  parameter int unsigned FrameCapacity = pbfp_pkg::FrameCapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  pbfp_stream_if.sink   in_s,
  pbfp_stream_if.source out_s
);
  import pbfp_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [9:0] x;
    logic [9:0] y;
  } verdict_t;

  logic [7:0] letter_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q  <= LetterRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRobotLetter: letter_q  <= cfg_wdata_i;
        CfgIdleTimeout: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pbfp_stream_if #(.payload_t(verdict_t)) fr_q ();
  pbfp_stream_if #(.payload_t(verdict_t)) q_bk ();

  pbfp_front #(.FrameCapacity(FrameCapacity)) u_front (
    .clk_i, .rst_ni, .robot_letter_i(letter_q), .idle_timeout_i(timeout_q),
    .in_s(in_s), .out_s(fr_q.source)
  );

  pbfp_fifo #(.payload_t(verdict_t)) u_fifo (
    .clk_i, .rst_ni, .in_s(fr_q.sink), .out_s(q_bk.source)
  );

  pbfp_back #(.verdict_t(verdict_t)) u_back (
    .clk_i, .rst_ni, .in_s(q_bk.sink), .out_s(out_s)
  );
endmodule

[dv/tb_position_broadcast_frame_parser_core.sv]
// Testbench for the position broadcast frame parser core: directed and random
// frames checked against an in-bench predictor of the parser.
// Depends on pbfp_pkg, pbfp_stream_if and the parser RTL.
module tb_position_broadcast_frame_parser_core;
  import pbfp_pkg::*;

  localparam int unsigned Capacity = FrameCapacityDef;
  localparam int unsigned HoldCycles = 300;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  pbfp_stream_if #(.payload_t(in_item_t))  in_ch ();
  pbfp_stream_if #(.payload_t(out_item_t)) out_ch ();

  position_broadcast_frame_parser_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_s       (in_ch.sink),
    .out_s      (out_ch.source)
  );

  // Predictor state: the parser as the testbench sees it.
  logic [7:0] p_letter, p_timeout;
  int unsigned p_len;
  logic       p_broken;
  logic [5:0] p_sum;
  logic [7:0] p_dly0, p_dly1;
  int unsigned p_phase;
  logic [9:0] p_acc, p_ex, p_fx, p_fy, p_cx, p_cy;
  logic       p_match, p_ebad, p_found, p_valid;
  logic [7:0] p_idle;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int unsigned n_sent, n_results, n_ok, n_mismatch;
  bit  hold_rx;
  bit  in_acc, out_acc;

  function automatic logic dig(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic void drop_frame();
    p_len = 0; p_broken = 0; p_sum = 0; p_dly0 = 0; p_dly1 = 0;
    p_phase = 0; p_acc = 0; p_match = 0; p_ebad = 0; p_ex = 0;
    p_found = 0; p_fx = 0; p_fy = 0;
  endfunction

  // Byte known to lie before the checksum digits, at frame index idx.
  function automatic void body_byte(logic [7:0] b, int unsigned idx);
    p_sum = p_sum + b[5:0];
    if (idx == 0) begin
      if (b != StartMark) p_broken = 1;
      return;
    end
    if (idx < 6) begin
      if (!dig(b)) p_broken = 1;
      return;
    end
    if (p_phase == 0) begin
      p_match = (b == p_letter); p_ebad = 0; p_acc = 0; p_phase = 1;
      return;
    end
    if (dig(b)) p_acc = 10'(p_acc * 10 + (b - 8'h30));
    else p_ebad = 1;
    if (p_phase == 3) begin
      p_ex = p_acc; p_acc = 0;
    end
    if (p_phase == 6) begin
      if (p_ebad) p_broken = 1;
      else if (p_match) begin
        p_found = 1; p_fx = p_ex; p_fy = p_acc;
      end
      p_acc = 0; p_phase = 0;
    end else begin
      p_phase++;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    if (b == 0) p_broken = 1;
    if (p_len >= 2) body_byte(p_dly0, p_len - 2);
    p_dly0 = p_dly1; p_dly1 = b; p_len++;
  endfunction

  // Advance the predictor by one accepted transaction.
  function automatic void predict_parser(in_item_t it);
    out_item_t r;
    logic ok;
    int unsigned tx;
    if (it.func) begin
      if (p_idle != 8'hFF) p_idle++;
      if (p_len > 0 && p_idle >= p_timeout) drop_frame();
      return;
    end
    p_idle = 0;
    if (it.rx_byte == StartMark) begin
      drop_frame(); push_byte(it.rx_byte);
      return;
    end
    if (it.rx_byte != EndMark) begin
      if (p_len < Capacity - 1) push_byte(it.rx_byte);
      else drop_frame();
      return;
    end
    ok = 0;
    if (p_len < Capacity - 1 && p_len + 1 >= 13 && !p_broken && dig(p_dly0) && dig(p_dly1))
    begin
      tx = (p_dly0 - 8'h30) * 10 + (p_dly1 - 8'h30);
      ok = (((p_sum + EndMark) & 8'h3F) == tx) && p_found;
    end
    if (ok) begin
      p_cx = p_fx; p_cy = p_fy; p_valid = 1;
    end
    drop_frame();
    r.frame_ok      = ok;
    r.pos_x         = p_cx;
    r.pos_y         = p_cy;
    r.has_position  = p_valid;
    r.in_start_zone = p_valid && p_cx >= 45 && p_cx <= 53 && p_cy >= 2 && p_cy <= 15;
    r.in_end_zone   = p_valid && p_cx >= 86 && p_cx <= 100 && p_cy >= 18 && p_cy <= 33;
    expected_q.push_back(r);
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Handshakes are seen at the rising edge and acted on at the next falling one.
  initial begin
    in_acc = 0; out_acc = 0;
  end
  always @(posedge clk_i) begin
    in_acc  = rst_ni && in_ch.valid && in_ch.ready;
    out_acc = rst_ni && out_ch.valid && out_ch.ready;
  end

  // Driver: one queued transaction at a time, random gap before each.
  int unsigned tx_gap;
  initial begin
    in_ch.valid = 0; in_ch.data = '0; tx_gap = 0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        // transaction taken at the rising edge just gone
        predict_parser(in_ch.data);
        void'(pending_q.pop_front());
        n_sent++;
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) tx_gap = 0;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 0;
      end else if (pending_q.size() > 0) begin
        in_ch.valid <= 1;
        in_ch.data  <= pending_q[0];
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver: random stall per result, plus a long hold-off when asked.
  int unsigned rx_gap, hold_cnt;
  initial begin
    out_ch.ready = 0; rx_gap = 0; hold_cnt = 0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc)
        rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (!hold_rx) hold_cnt = 0;
      if (hold_rx && hold_cnt < HoldCycles) begin
        hold_cnt++;
        out_ch.ready <= 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 0;
      end else out_ch.ready <= 1;
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        e = expected_q.pop_front();
        if (e.frame_ok) n_ok++;
        if (out_ch.data !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result mismatch: expected %p, got %p", e, out_ch.data);
        end
      end
    end
  end

  // Stimulus helpers -------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.func = 0; it.rx_byte = b;
    pending_q.push_back(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.func = 1; it.rx_byte = 8'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic send_num(int unsigned v);
    send_byte(8'(8'h30 + v / 100));
    send_byte(8'(8'h30 + (v / 10) % 10));
    send_byte(8'(8'h30 + v % 10));
  endtask

  // Build a frame: n entries, one of them perhaps ours; checksum optionally
  // spoiled. The bytes are collected first so the sum can be formed.
  task automatic send_frame(int unsigned n_ent, logic [7:0] self_letter,
                            int unsigned self_pos, int unsigned x, int unsigned y,
                            bit good_sum, int unsigned tail);
    logic [7:0] buf_q[$];
    int unsigned s, xv, yv;
    buf_q.push_back(StartMark);
    buf_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    repeat (4) buf_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    for (int unsigned i = 0; i < n_ent; i++) begin
      xv = (i == self_pos) ? x : $urandom_range(0, 999);
      yv = (i == self_pos) ? y : $urandom_range(0, 999);
      buf_q.push_back((i == self_pos) ? self_letter : 8'(8'h41 + $urandom_range(0, 25)));
      buf_q.push_back(8'(8'h30 + xv / 100)); buf_q.push_back(8'(8'h30 + (xv / 10) % 10));
      buf_q.push_back(8'(8'h30 + xv % 10));
      buf_q.push_back(8'(8'h30 + yv / 100)); buf_q.push_back(8'(8'h30 + (yv / 10) % 10));
      buf_q.push_back(8'(8'h30 + yv % 10));
    end
    repeat (tail) buf_q.push_back(8'($urandom_range(1, 255)) | 8'h01);
    foreach (buf_q[i]) if (buf_q[i] == StartMark || buf_q[i] == EndMark) buf_q[i] = 8'h41;
    buf_q[0] = StartMark;
    s = 32'(EndMark);
    foreach (buf_q[i]) s += buf_q[i];
    s = s % 64;
    if (!good_sum) s = (s + $urandom_range(1, 35)) % 100;
    foreach (buf_q[i]) send_byte(buf_q[i]);
    send_byte(8'(8'h30 + s / 10));
    send_byte(8'(8'h30 + s % 10));
    send_byte(EndMark);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
      @(posedge clk_i);
    // a frame with no result may still be in flight: allow the pipeline depth
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == CfgRobotLetter) p_letter = v;
    else p_timeout = v;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned k;
    while (n_sent < n) begin
      k = $urandom_range(0, 19);
      if (k < 12)
        send_frame($urandom_range(0, 5), p_letter, $urandom_range(0, 5),
                   ($urandom_range(0, 1)) ? $urandom_range(40, 105) : $urandom_range(0, 999),
                   ($urandom_range(0, 1)) ? $urandom_range(0, 40) : $urandom_range(0, 999),
                   $urandom_range(0, 4) != 0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      else if (k < 14) repeat ($urandom_range(1, 4)) send_tick();
      else if (k < 17) repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      else if (k < 18) send_byte(EndMark);
      else if (k < 19) begin
        // partial frame followed by idle ticks
        send_byte(StartMark); send_num($urandom_range(0, 999));
        repeat ($urandom_range(0, 7)) send_tick();
        send_byte(EndMark);
      end else send_frame(17, p_letter, $urandom_range(0, 17), 50, 10, 1, 0); // overflow
      while (pending_q.size() > 40) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = CfgRobotLetter; cfg_wdata_i = 0;
    hold_rx = 0;
    n_sent = 0; n_results = 0; n_ok = 0; n_mismatch = 0;
    p_letter = LetterRst; p_timeout = TimeoutRst;
    drop_frame(); p_cx = 0; p_cy = 0; p_valid = 0; p_idle = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // Directed part: reset letter, zones, checksum errors, special cases.
    send_frame(1, LetterRst, 0, 49, 8, 1, 0);        // start zone
    send_frame(3, LetterRst, 2, 90, 20, 1, 0);       // end zone, last entry ours
    send_frame(2, LetterRst, 0, 999, 999, 0, 0);     // bad checksum
    send_frame(0, LetterRst, 0, 0, 0, 1, 0);         // valid, no entry of ours
    send_frame(1, LetterRst, 0, 0, 0, 1, 3);         // trailing partial entry
    send_byte(8'h31); send_byte(EndMark);            // bytes before any start mark
    send_byte(StartMark); send_byte(8'h00); send_byte(EndMark); // zero byte
    send_byte(StartMark); send_num(123); send_byte(StartMark);  // restart mark
    send_byte(8'hFF); send_byte(EndMark);
    drain();

    // Long receiver hold-off while frames keep arriving.
    hold_rx = 1;
    repeat (6) send_frame(0, LetterRst, 0, 0, 0, 1, 0);
    wait (hold_cnt == HoldCycles);
    hold_rx = 0;
    drain();

    write_cfg(CfgRobotLetter, 8'h00);
    write_cfg(CfgIdleTimeout, 8'd1);
    random_phase(250);
    drain();
    write_cfg(CfgRobotLetter, 8'hFF);
    write_cfg(CfgIdleTimeout, 8'hFF);
    random_phase(500);
    drain();
    write_cfg(CfgRobotLetter, 8'h4B);
    write_cfg(CfgIdleTimeout, 8'd3);
    random_phase(800);
    drain();

    $display("Sent %0d transactions under the reset and three written register settings,",
             n_sent);
    $display("with a long receiver hold-off; %0d results (%0d ok).", n_results, n_ok);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("tb_position_broadcast_frame_parser_core: clean");
    end else begin
      $display("tb_position_broadcast_frame_parser_core: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_position_broadcast_frame_parser_core: errors");
    $finish;
  end

endmodule
